@@ design/tmc_pkg.sv @@
// Shared types and constants for the triggered multichannel capture block.
// Holds the register file layout, register indexes and the result record.
// No dependencies.
package tmc_pkg;

  localparam int CHANNELS  = 4;
  localparam int MAX_BLOCK = 4096;
  localparam int SAMPLE_W  = 16;
  // Width that holds block lengths up to and including MAX_BLOCK.
  localparam int LEN_W     = $clog2(MAX_BLOCK + 1);
  // Width of the position index inside one block.
  localparam int POS_W     = $clog2(MAX_BLOCK);
  localparam int SRC_W     = $clog2(CHANNELS);
  localparam int CNT_W     = 3;
  localparam int IDX_W     = 8;
  localparam int CFG_W     = 16;

  localparam logic [CNT_W-1:0] CHAN_COUNT_RESET = CNT_W'(1);
  localparam logic [LEN_W-1:0] BLOCK_LEN_RESET  = LEN_W'(1024);
  localparam logic [LEN_W-1:0] MAX_BLOCK_LEN    = LEN_W'(MAX_BLOCK);

  typedef enum logic [IDX_W-1:0] {
    REG_CHANNEL_COUNT  = 8'd0,
    REG_BLOCK_LENGTH   = 8'd1,
    REG_TRIGGER_ENABLE = 8'd2,
    REG_TRIGGER_SOURCE = 8'd3
  } reg_index_t;

  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

  typedef struct packed {
    logic [CNT_W-1:0] channel_count;
    logic [LEN_W-1:0] block_length;
    logic             trigger_enable;
    logic [SRC_W-1:0] trigger_source;
    logic             length_write;   // one-cycle pulse when block_length is written
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] position;
    frame_t           samples;
  } result_t;

endpackage

@@ design/tmc_regs.sv @@
// Configuration register file of the triggered multichannel capture block.
// Decodes writes on the configuration channel; depends on tmc_pkg.
module tmc_regs import tmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  logic             wr;
  logic [CNT_W-1:0] channel_count;
  logic [LEN_W-1:0] block_length;
  logic             trigger_enable;
  logic [SRC_W-1:0] trigger_source;
  logic             length_write;

  // The channel is always ready, so every valid request is a write.
  assign wr = cfg_valid;

  // The block count is cleared at the same edge that takes the new length.
  assign length_write = wr && (cfg_index == REG_BLOCK_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count  <= CHAN_COUNT_RESET;
      block_length   <= BLOCK_LEN_RESET;
      trigger_enable <= 1'b0;
      trigger_source <= '0;
    end else begin
      if (wr) begin
        case (cfg_index)
          REG_CHANNEL_COUNT:  channel_count  <= cfg_data[CNT_W-1:0];
          REG_BLOCK_LENGTH:   block_length   <= cfg_data[LEN_W-1:0];
          REG_TRIGGER_ENABLE: trigger_enable <= cfg_data[0];
          REG_TRIGGER_SOURCE: trigger_source <= cfg_data[SRC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg = '{channel_count:  channel_count,
                 block_length:   block_length,
                 trigger_enable: trigger_enable,
                 trigger_source: trigger_source,
                 length_write:   length_write};

endmodule

@@ design/tmc_core.sv @@
// Trigger detection and block sequencing for the capture block.
// Builds the result for each accepted frame and updates capture state; uses tmc_pkg.
module tmc_core import tmc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  frame_t  frame,
  input  cfg_t    cfg,
  output logic    emit,
  output result_t result
);

  logic [SAMPLE_W-1:0] previous_trigger_sample;
  logic                previous_valid;
  logic                capture_active;
  logic [LEN_W-1:0]    frames_captured;

  logic [SAMPLE_W-1:0] cur;
  logic                edge_found;
  logic [LEN_W-1:0]    eff_len;
  logic [LEN_W-1:0]    pos;
  logic [LEN_W:0]      pos_inc;
  logic                last;
  logic                capture_active_next;
  logic [LEN_W-1:0]    frames_captured_next;

  always_comb begin
    cur        = frame[cfg.trigger_source];
    edge_found = previous_valid && ($signed(previous_trigger_sample) <= 0)
                 && ($signed(cur) > 0);

    if (cfg.block_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.block_length > MAX_BLOCK_LEN) begin
      eff_len = MAX_BLOCK_LEN;
    end else begin
      eff_len = cfg.block_length;
    end

    emit                 = 1'b1;
    capture_active_next  = capture_active;
    pos                  = frames_captured;
    if (cfg.trigger_enable && !capture_active) begin
      if (edge_found) begin
        capture_active_next = 1'b1;
        pos                 = '0;
      end else begin
        emit = 1'b0;
      end
    end

    pos_inc = {1'b0, pos} + (LEN_W+1)'(1);
    last    = pos_inc >= {1'b0, eff_len};
    if (last) begin
      frames_captured_next = '0;
      capture_active_next  = 1'b0;
    end else begin
      frames_captured_next = pos_inc[LEN_W-1:0];
    end

    for (int i = 0; i < CHANNELS; i++) begin
      result.samples[i] = (i < int'(cfg.channel_count)) ? frame[i] : '0;
    end
    result.position = pos[POS_W-1:0];
    result.done     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_trigger_sample <= '0;
      previous_valid          <= 1'b0;
      capture_active          <= 1'b0;
      frames_captured         <= '0;
    end else begin
      if (accept) begin
        previous_trigger_sample <= cur;
        previous_valid          <= 1'b1;
        if (emit) begin
          capture_active <= capture_active_next;
        end
      end
      // Writing the block length restarts the block count.
      if (cfg.length_write) begin
        frames_captured <= '0;
      end else if (accept && emit) begin
        frames_captured <= frames_captured_next;
      end
    end
  end

endmodule

@@ design/tmc_skid.sv @@
// Output register with a skid stage for the capture block result stream.
// Keeps the input ready while one result waits downstream; uses tmc_pkg.
module tmc_skid import tmc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    out_free;

  assign ready    = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= push_data;
        out_valid <= push;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

@@ design/triggered_multichannel_capture.sv @@
// Triggered multichannel capture: oscilloscope front end with rising-edge trigger.
// The output is registered: an accepted frame shows on the master side from the output or skid register.
// Accepts one frame per cycle while s_tready is high; the skid stage keeps s_tready high
// while one result waits downstream, so input only stalls when the output holds two results.
// Reset (rst, synchronous, active high) clears capture state and loads register defaults.
// Depends on tmc_pkg, tmc_regs, tmc_core and tmc_skid.
module triggered_multichannel_capture import tmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // Sample frames in. Fields from bit 0 up: sample_ch0, sample_ch1, sample_ch2,
  // sample_ch3, each 16-bit signed Q1.15.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,
  // Captured frames out. Fields from bit 0 up: captured_ch0, captured_ch1,
  // captured_ch2, captured_ch3 (16 bits each), position_in_block (12 bits),
  // then four zero pad bits.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [79:0]      m_tdata,
  output logic             m_tlast,   // block_done
  // Configuration write channel.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t    cfg;
  frame_t  frame;
  logic    accept;
  logic    emit;
  result_t result;
  result_t out_data;
  logic    push;

  // Register writes never stall, so the channel is always ready.
  assign cfg_ready = 1'b1;

  tmc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The packed frame type places channel 0 in the lowest bits, as on the bus.
  assign frame  = frame_t'(s_tdata);
  assign accept = s_tvalid && s_tready;

  // The core updates its trigger history on every accepted request, and only
  // emits a result when not armed or when the trigger edge arrives.
  tmc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .frame  (frame),
    .cfg    (cfg),
    .emit   (emit),
    .result (result)
  );

  assign push = accept && emit;

  tmc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {4'b0000, out_data.position, out_data.samples};
  assign m_tlast = out_data.done;

endmodule
